/* rtl/tbpf_pkg.sv */
// package for the tiled background pixel fetch: sizes, codes, controller types
package tbpf_pkg;

  localparam int VIDEO_HALFWORDS = 32768;
  localparam int PAL_ENTRIES     = 256;
  localparam int SCREEN_WIDTH    = 240;

  localparam int VADDR_W = $clog2(VIDEO_HALFWORDS);
  localparam int PAL_AW  = $clog2(PAL_ENTRIES);

  localparam int CMD_W   = 2;
  localparam int WADDR_W = 15;
  localparam int WDATA_W = 16;
  localparam int COORD_W = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [CMD_W-1:0] CMD_WR_VIDEO = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_PAL   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RENDER   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CHAR_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_256   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_BASE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_SIZE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_X    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_Y    = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_TILE,
    ST_PAL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic map_rd;
    logic tile_rd;
    logic pal_rd;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic render_ok;
  } dp_status_t;

endpackage

/* rtl/tiled_background_pixel_fetch.sv */
// top level of the tiled background pixel fetch
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  command, write_address, write_data, pixel_x, line
//  out      output     out_valid/out_stall  red, green, blue, opaque, pixel_priority
//  cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// write items are taken in the accept step alone; a render item steps through accept,
// map read, tile read, palette read and result load, set by the dependent memory reads.
// synchronous active-low reset clears the state machine, result valid and config.
// memory contents are not cleared. a new item is taken while a result waits;
// the result load waits only while a shown result is stalled.
module tiled_background_pixel_fetch (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tbpf_pkg::CMD_W-1:0]        in_command,
  input  logic [tbpf_pkg::WADDR_W-1:0]      in_write_address,
  input  logic [tbpf_pkg::WDATA_W-1:0]      in_write_data,
  input  logic [tbpf_pkg::COORD_W-1:0]      in_pixel_x,
  input  logic [tbpf_pkg::COORD_W-1:0]      in_line,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_red,
  output logic [7:0]                        out_green,
  output logic [7:0]                        out_blue,
  output logic                              out_opaque,
  output logic [1:0]                        out_pixel_priority,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tbpf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tbpf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  tbpf_pkg::ctrl_cmd_t  cmd;
  tbpf_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  tbpf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  tbpf_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_command        (in_command),
    .in_write_address  (in_write_address),
    .in_write_data     (in_write_data),
    .in_pixel_x        (in_pixel_x),
    .in_line           (in_line),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_opaque        (out_opaque),
    .out_pixel_priority(out_pixel_priority)
  );

endmodule

/* rtl/tbpf_ram.sv */
// generic single write, single read ram with registered read data
module tbpf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/tbpf_ctrl.sv */
// controller state machine: handshakes and sequencing of the three memory reads
module tbpf_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  tbpf_pkg::dp_status_t   status,
  output tbpf_pkg::ctrl_cmd_t    cmd
);

  tbpf_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tbpf_pkg::ST_IDLE: begin
        if (in_valid && status.render_ok) begin
          state_nxt = tbpf_pkg::ST_MAP;
        end
      end
      tbpf_pkg::ST_MAP:  state_nxt = tbpf_pkg::ST_TILE;
      tbpf_pkg::ST_TILE: state_nxt = tbpf_pkg::ST_PAL;
      tbpf_pkg::ST_PAL:  state_nxt = tbpf_pkg::ST_OUT;
      tbpf_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = tbpf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tbpf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      tbpf_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      tbpf_pkg::ST_MAP:  cmd.map_rd  = 1'b1;
      tbpf_pkg::ST_TILE: cmd.tile_rd = 1'b1;
      tbpf_pkg::ST_PAL:  cmd.pal_rd  = 1'b1;
      tbpf_pkg::ST_OUT:  cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tbpf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_render_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tbpf_pkg::ST_IDLE && in_valid && status.render_ok)
      |=> (state_r == tbpf_pkg::ST_MAP))
    else $error("accepted render did not start the map read");

  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.map_rd, cmd.tile_rd, cmd.pal_rd, cmd.out_load}))
    else $error("more than one datapath step at once");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not shown");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while stalled");

endmodule

/* rtl/tbpf_dp.sv */
// datapath: config registers, address generation, video and palette memories, result
module tbpf_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tbpf_pkg::ctrl_cmd_t               cmd,
  output tbpf_pkg::dp_status_t              status,
  input  logic [tbpf_pkg::CMD_W-1:0]        in_command,
  input  logic [tbpf_pkg::WADDR_W-1:0]      in_write_address,
  input  logic [tbpf_pkg::WDATA_W-1:0]      in_write_data,
  input  logic [tbpf_pkg::COORD_W-1:0]      in_pixel_x,
  input  logic [tbpf_pkg::COORD_W-1:0]      in_line,
  input  logic                              cfg_valid,
  input  logic [tbpf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tbpf_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic [7:0]                        out_red,
  output logic [7:0]                        out_green,
  output logic [7:0]                        out_blue,
  output logic                              out_opaque,
  output logic [1:0]                        out_pixel_priority
);

  localparam int VAW = tbpf_pkg::VADDR_W;
  localparam int PAW = tbpf_pkg::PAL_AW;

  function automatic logic [7:0] widen5(input logic [4:0] c);
    widen5 = {c, c[4:2]};
  endfunction

  // config registers
  logic [1:0] char_base_r;
  logic       color_256_r;
  logic [4:0] screen_base_r;
  logic [1:0] screen_size_r;
  logic [1:0] priority_r;
  logic [8:0] scroll_x_r;
  logic [8:0] scroll_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_base_r   <= '0;
      color_256_r   <= 1'b0;
      screen_base_r <= '0;
      screen_size_r <= '0;
      priority_r    <= '0;
      scroll_x_r    <= '0;
      scroll_y_r    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        tbpf_pkg::CFG_CHAR_BASE:   char_base_r   <= cfg_data[1:0];
        tbpf_pkg::CFG_COLOR_256:   color_256_r   <= cfg_data[0];
        tbpf_pkg::CFG_SCREEN_BASE: screen_base_r <= cfg_data[4:0];
        tbpf_pkg::CFG_SCREEN_SIZE: screen_size_r <= cfg_data[1:0];
        tbpf_pkg::CFG_PRIORITY:    priority_r    <= cfg_data[1:0];
        tbpf_pkg::CFG_SCROLL_X:    scroll_x_r    <= cfg_data[8:0];
        tbpf_pkg::CFG_SCROLL_Y:    scroll_y_r    <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // item decode and memory writes
  logic [9:0]  px_ext;
  logic        vid_we, pal_we;
  logic [16:0] waddr_ext;

  assign px_ext           = {2'b0, in_pixel_x};
  assign status.render_ok = (in_command == tbpf_pkg::CMD_RENDER)
                            && (px_ext < 10'(tbpf_pkg::SCREEN_WIDTH));
  assign vid_we    = cmd.accept && (in_command == tbpf_pkg::CMD_WR_VIDEO);
  assign pal_we    = cmd.accept && (in_command == tbpf_pkg::CMD_WR_PAL);
  assign waddr_ext = {2'b0, in_write_address};

  // scrolled, wrapped map coordinates
  logic [8:0] ex_r, ex_nxt, ey_r, ey_nxt;
  logic [8:0] sum_x, sum_y;

  assign sum_x  = {1'b0, in_pixel_x} + scroll_x_r;
  assign sum_y  = {1'b0, in_line} + scroll_y_r;
  assign ex_nxt = {sum_x[8] & screen_size_r[0], sum_x[7:0]};
  assign ey_nxt = {sum_y[8] & screen_size_r[1], sum_y[7:0]};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ex_r <= ex_nxt;
      ey_r <= ey_nxt;
    end
  end

  // map entry address
  logic [1:0]  block;
  logic [5:0]  map_block;
  logic [16:0] map_full;

  assign block     = (screen_size_r == 2'd2) ? {1'b0, ey_r[8]} : {ey_r[8], ex_r[8]};
  assign map_block = {1'b0, screen_base_r} + {4'b0, block};
  assign map_full  = {1'b0, map_block, ey_r[7:3], ex_r[7:3]};

  // tile pixel address from the map entry
  logic [15:0] vid_rdata;
  logic [2:0]  lx, ly;
  logic [17:0] tile_base, tile_off, tile_byte;

  assign lx = vid_rdata[10] ? ~ex_r[2:0] : ex_r[2:0];
  assign ly = vid_rdata[11] ? ~ey_r[2:0] : ey_r[2:0];
  assign tile_base = {2'b0, char_base_r, 14'b0};
  assign tile_off  = color_256_r ? {2'b0, vid_rdata[9:0], ly, lx}
                                 : {3'b0, vid_rdata[9:0], ly, lx[2:1]};
  assign tile_byte = tile_base + tile_off;

  logic       odd_r, nib_r;
  logic [3:0] bank_r;

  always_ff @(posedge clk) begin
    if (cmd.tile_rd) begin
      odd_r  <= tile_byte[0];
      nib_r  <= lx[0];
      bank_r <= vid_rdata[15:12];
    end
  end

  logic [VAW-1:0] vid_raddr;
  logic           vid_re;

  assign vid_re    = cmd.map_rd || cmd.tile_rd;
  assign vid_raddr = cmd.tile_rd ? tile_byte[VAW:1] : map_full[VAW-1:0];

  tbpf_ram #(
    .WIDTH(16),
    .DEPTH(tbpf_pkg::VIDEO_HALFWORDS)
  ) u_vram (
    .clk  (clk),
    .we   (vid_we),
    .waddr(waddr_ext[VAW-1:0]),
    .wdata(in_write_data),
    .re   (vid_re),
    .raddr(vid_raddr),
    .rdata(vid_rdata)
  );

  // colour index and palette lookup
  logic [7:0] tbyte, cidx, pidx;
  logic       opaque_r;

  assign tbyte = odd_r ? vid_rdata[15:8] : vid_rdata[7:0];
  assign cidx  = color_256_r ? tbyte : {4'b0, (nib_r ? tbyte[7:4] : tbyte[3:0])};
  assign pidx  = color_256_r ? tbyte : {bank_r, cidx[3:0]};

  always_ff @(posedge clk) begin
    if (cmd.pal_rd) begin
      opaque_r <= (cidx != 8'd0);
    end
  end

  logic [14:0] pal_rdata;

  tbpf_ram #(
    .WIDTH(15),
    .DEPTH(tbpf_pkg::PAL_ENTRIES)
  ) u_pal (
    .clk  (clk),
    .we   (pal_we),
    .waddr(waddr_ext[PAW-1:0]),
    .wdata(in_write_data[14:0]),
    .re   (cmd.pal_rd),
    .raddr(pidx[PAW-1:0]),
    .rdata(pal_rdata)
  );

  // result register
  logic [7:0] red_r, green_r, blue_r;
  logic       opq_r;
  logic [1:0] prio_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      red_r   <= opaque_r ? widen5(pal_rdata[4:0])   : 8'd0;
      green_r <= opaque_r ? widen5(pal_rdata[9:5])   : 8'd0;
      blue_r  <= opaque_r ? widen5(pal_rdata[14:10]) : 8'd0;
      opq_r   <= opaque_r;
      prio_r  <= priority_r;
    end
  end

  assign out_red            = red_r;
  assign out_green          = green_r;
  assign out_blue           = blue_r;
  assign out_opaque         = opq_r;
  assign out_pixel_priority = prio_r;

endmodule
